// File: rtl/core/phsh_pkg.sv
`timescale 1ns / 1ps
// Package for the popcount/shift byte hash: microcode word layout, step addresses,
// the control ROM and small helper functions. No dependencies.
package phsh_pkg;

  localparam int PHSH_MAX_WORDS = 32;     // default depth of the hash store
  localparam int PHSH_CFG_W     = 6;      // width of the word-count register
  localparam int PHSH_POS_W     = 7;      // chunk position width
  localparam int PHSH_WORD_W    = 32;
  localparam int PHSH_IDX_OUT_W = 5;      // width of the emitted word index
  localparam logic [PHSH_CFG_W-1:0] PHSH_CFG_RESET = 6'd8;

  localparam int STEP_W = 4;
  typedef logic [STEP_W-1:0] step_t;

  // Step addresses of the control program
  localparam step_t STEP_WAIT      = 4'd0;
  localparam step_t STEP_ABSORB    = 4'd1;
  localparam step_t STEP_WALK_LOAD = 4'd2;
  localparam step_t STEP_WALK_STEP = 4'd3;
  localparam step_t STEP_CHECK     = 4'd4;
  localparam step_t STEP_PAD       = 4'd5;
  localparam step_t STEP_EMIT_READ = 4'd6;
  localparam step_t STEP_EMIT_LOAD = 4'd7;
  localparam step_t STEP_EMIT_NEXT = 4'd8;
  localparam step_t STEP_CLEAR     = 4'd9;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_ABSORB,
    OP_WLOAD,
    OP_WSTEP,
    OP_PAD_ON,
    OP_EREAD,
    OP_ELOAD,
    OP_EINC,
    OP_CLEAR
  } op_t;

  typedef enum logic [3:0] {
    C_ALWAYS,
    C_NEVER,
    C_NO_ACCEPT,
    C_NO_WALK,
    C_WALK_MORE,
    C_NOT_ENDING,
    C_PAD_MORE,
    C_SLOT_BUSY,
    C_EMIT_MORE
  } cond_t;

  typedef struct packed {
    logic  in_ready;
    op_t   op;
    cond_t cond;
    step_t target;
  } ctrl_t;

  // Status flags from the datapath, sampled by the branch logic
  typedef struct packed {
    logic accept;
    logic walk_due;
    logic walk_more;
    logic ending;
    logic pad_more;
    logic slot_busy;
    logic emit_more;
  } flags_t;

  // Control program: branch to target when the condition holds, else fall through
  function automatic ctrl_t phsh_rom(input step_t addr);
    ctrl_t w;
    w = '{in_ready: 1'b0, op: OP_NOP, cond: C_ALWAYS, target: STEP_WAIT};
    unique case (addr)
      STEP_WAIT:      w = '{1'b1, OP_NOP,    C_NO_ACCEPT,  STEP_WAIT};
      STEP_ABSORB:    w = '{1'b0, OP_ABSORB, C_NO_WALK,    STEP_CHECK};
      STEP_WALK_LOAD: w = '{1'b0, OP_WLOAD,  C_NEVER,      STEP_WAIT};
      STEP_WALK_STEP: w = '{1'b0, OP_WSTEP,  C_WALK_MORE,  STEP_WALK_STEP};
      STEP_CHECK:     w = '{1'b0, OP_NOP,    C_NOT_ENDING, STEP_WAIT};
      STEP_PAD:       w = '{1'b0, OP_PAD_ON, C_PAD_MORE,   STEP_ABSORB};
      STEP_EMIT_READ: w = '{1'b0, OP_EREAD,  C_NEVER,      STEP_WAIT};
      STEP_EMIT_LOAD: w = '{1'b0, OP_ELOAD,  C_SLOT_BUSY,  STEP_EMIT_LOAD};
      STEP_EMIT_NEXT: w = '{1'b0, OP_EINC,   C_EMIT_MORE,  STEP_EMIT_READ};
      STEP_CLEAR:     w = '{1'b0, OP_CLEAR,  C_ALWAYS,     STEP_WAIT};
      default:        w = '{1'b0, OP_NOP,    C_ALWAYS,     STEP_WAIT};
    endcase
    return w;
  endfunction

  function automatic logic [3:0] popcnt8(input logic [7:0] v);
    logic [3:0] n;
    n = 4'd0;
    for (int b = 0; b < 8; b++) begin
      n = n + 4'(v[b]);
    end
    return n;
  endfunction

endpackage

// File: rtl/core/phsh_ram.sv
`timescale 1ns / 1ps
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module phsh_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic                                  re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/core/phsh_seq.sv
`timescale 1ns / 1ps
// Microcode sequencer: step counter, control ROM lookup and conditional branch.
// Depends on phsh_pkg.
module phsh_seq (
  input  logic            clk,
  input  logic            rst_n,
  input  phsh_pkg::flags_t flags,
  output phsh_pkg::ctrl_t  ctrl
);
  import phsh_pkg::*;

  step_t step_r, step_nxt;
  logic  take;

  assign ctrl = phsh_rom(step_r);

  always_comb begin
    unique case (ctrl.cond)
      C_ALWAYS:     take = 1'b1;
      C_NEVER:      take = 1'b0;
      C_NO_ACCEPT:  take = !flags.accept;
      C_NO_WALK:    take = !flags.walk_due;
      C_WALK_MORE:  take = flags.walk_more;
      C_NOT_ENDING: take = !flags.ending;
      C_PAD_MORE:   take = flags.pad_more;
      C_SLOT_BUSY:  take = flags.slot_busy;
      C_EMIT_MORE:  take = flags.emit_more;
      default:      take = 1'b0;
    endcase
  end

  always_comb begin
    step_nxt = take ? ctrl.target : step_r + step_t'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= STEP_WAIT;
    end else begin
      step_r <= step_nxt;
    end
  end

endmodule

// File: rtl/core/popcount_shift_byte_hash_top.sv
`timescale 1ns / 1ps
// Top level of the popcount/shift byte hash: datapath, hash store and output register.
// Depends on phsh_pkg, phsh_seq and phsh_ram.
//
//  Channel | Direction | Handshake           | Payload
//  --------+-----------+---------------------+------------------------------------------
//  in_     | slave     | in_tvalid/in_tready | tdata: data_byte; tlast: last_byte
//  out_    | master    | out_tvalid/tready   | tdata: hash_word, word_index; tlast: last_word
//  cfg_    | slave     | cfg_valid/cfg_ready | cfg_data: hash_words (always ready)
//
// A byte passes the wait/transfer, absorb into word 0 and check steps. Every 16th byte of a
// chunk and each chunk end add a carry walk when W exceeds one, paced by the single RAM
// read port (one word per cycle, word 0 lives in a register). A last byte then pads the
// chunk out at the same per-byte cost and emits the W words by read, load and next steps.
// Synchronous active-low reset; per-entry valid bits make the store read as zero at once,
// so there is no clearing pass. A stalled output holds the sequencer in its emit step.
module popcount_shift_byte_hash_top #(
  parameter int MAX_WORDS = phsh_pkg::PHSH_MAX_WORDS
) (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,    // [7:0] data_byte
  input  logic        in_tlast,    // last_byte
  // result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,   // [31:0] hash_word, [36:32] word_index, [39:37] zero
  output logic        out_tlast,   // last_word
  // configuration
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [phsh_pkg::PHSH_CFG_W-1:0] cfg_data  // hash_words
);
  import phsh_pkg::*;

  localparam int IDX_W = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
  localparam logic [PHSH_CFG_W-1:0] MAXW = PHSH_CFG_W'(MAX_WORDS);

  typedef logic [IDX_W-1:0] idx_t;

  ctrl_t  ctrl;
  flags_t flags;

  // configuration and derived word count
  logic [PHSH_CFG_W-1:0] words_cfg_r;
  logic [PHSH_CFG_W-1:0] w_eff;
  idx_t                  w_last;

  // message state
  logic [PHSH_WORD_W-1:0] acc0_r, acc0_nxt;        // hash word 0
  logic [7:0]             prev_r, prev_nxt;
  logic [PHSH_POS_W-1:0]  pos_r, pos_nxt;
  logic                   start_r, start_nxt;
  logic                   pad_r, pad_nxt;
  logic [7:0]             byte_r;
  logic                   last_r;

  // carry walk / emit
  idx_t                   idx_r, idx_nxt;
  logic [PHSH_WORD_W-1:0] src_r, src_nxt;
  logic [MAX_WORDS-1:0]   valid_r, valid_nxt;
  logic                   rd_valid_r, rd_valid_nxt;

  // output register
  logic                      out_valid_r, out_valid_nxt;
  logic [PHSH_WORD_W-1:0]    out_word_r, out_word_nxt;
  logic [PHSH_IDX_OUT_W-1:0] out_index_r, out_index_nxt;
  logic                      out_last_r, out_last_nxt;

  // RAM port
  logic                   ram_we, ram_re;
  idx_t                   ram_waddr, ram_raddr;
  logic [PHSH_WORD_W-1:0] ram_wdata, ram_rdata;

  // absorb datapath
  logic [7:0]             abs_c, abs_p;
  logic [3:0]             pc_c, shamt;
  logic [15:0]            shifted;
  logic [PHSH_WORD_W-1:0] abs_sum;
  logic [7:0]             pos_inc, chunk_len;
  logic                   chunk_end, walk_due;

  logic [PHSH_WORD_W-1:0] mem_word, walk_sum;
  logic                   in_xfer, slot_busy;

  assign cfg_ready = 1'b1;
  assign in_tready = ctrl.in_ready;
  assign in_xfer   = in_tvalid && in_tready;

  // clamp the word count into 1..MAX_WORDS
  always_comb begin
    priority if (words_cfg_r == '0) begin
      w_eff = PHSH_CFG_W'(1);
    end else if (words_cfg_r > MAXW) begin
      w_eff = MAXW;
    end else begin
      w_eff = words_cfg_r;
    end
  end
  assign w_last = IDX_W'(w_eff - PHSH_CFG_W'(1));

  // absorb: pad bytes are their own chunk position
  assign abs_c     = pad_r ? {1'b0, pos_r} : byte_r;
  assign abs_p     = start_r ? abs_c : prev_r;
  assign pc_c      = popcnt8(abs_c);
  assign shamt     = popcnt8(abs_c ^ abs_p);
  assign shifted   = 16'(abs_c) << shamt;
  assign abs_sum   = acc0_r + {4'b0, pc_c, 24'b0} + {16'b0, shifted};
  assign pos_inc   = {1'b0, pos_r} + 8'd1;
  assign chunk_len = {w_eff, 2'b00};
  assign chunk_end = (pos_inc >= chunk_len);
  assign walk_due  = (pos_inc[3:0] == 4'd0) || chunk_end;

  // walk: top nibble and bits 23:16 of the previous word land in disjoint bit ranges
  assign mem_word  = rd_valid_r ? ram_rdata : '0;
  assign walk_sum  = mem_word + {4'b0, src_r[31:28], 16'b0, src_r[23:16]};
  assign slot_busy = out_valid_r && !out_tready;

  always_comb begin
    flags.accept    = in_xfer;
    flags.walk_due  = walk_due && (w_eff > PHSH_CFG_W'(1));
    flags.walk_more = (idx_r != w_last);
    flags.ending    = last_r;
    flags.pad_more  = (pos_r != '0) || !pad_r;
    flags.slot_busy = slot_busy;
    flags.emit_more = (idx_r != w_last);
  end

  phsh_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .flags (flags),
    .ctrl  (ctrl)
  );

  phsh_ram #(
    .WIDTH (PHSH_WORD_W),
    .DEPTH (MAX_WORDS)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // datapath actions, one per control word
  always_comb begin
    acc0_nxt      = acc0_r;
    prev_nxt      = prev_r;
    pos_nxt       = pos_r;
    start_nxt     = start_r;
    pad_nxt       = pad_r;
    idx_nxt       = idx_r;
    src_nxt       = src_r;
    valid_nxt     = valid_r;
    out_word_nxt  = out_word_r;
    out_index_nxt = out_index_r;
    out_last_nxt  = out_last_r;
    out_valid_nxt = out_valid_r && !out_tready;   // drop the word once transferred
    ram_we        = 1'b0;
    ram_waddr     = idx_r;
    ram_wdata     = walk_sum;
    ram_re        = 1'b0;
    ram_raddr     = idx_r;

    unique case (ctrl.op)
      OP_NOP: begin
      end
      OP_ABSORB: begin
        acc0_nxt  = abs_sum;
        prev_nxt  = abs_c;
        start_nxt = 1'b0;
        pos_nxt   = chunk_end ? '0 : pos_inc[PHSH_POS_W-1:0];
      end
      OP_WLOAD: begin
        // word 0 is the first carry source; fetch word 1
        src_nxt   = acc0_r;
        idx_nxt   = idx_t'(1);
        ram_re    = 1'b1;
        ram_raddr = idx_t'(1);
      end
      OP_WSTEP: begin
        ram_we            = 1'b1;
        valid_nxt[idx_r]  = 1'b1;
        src_nxt           = walk_sum;
        ram_re            = 1'b1;
        ram_raddr         = idx_r + idx_t'(1);
        idx_nxt           = idx_r + idx_t'(1);
      end
      OP_PAD_ON: begin
        pad_nxt = 1'b1;
        idx_nxt = '0;
      end
      OP_EREAD: begin
        ram_re = 1'b1;
      end
      OP_ELOAD: begin
        if (!slot_busy) begin
          out_valid_nxt = 1'b1;
          out_word_nxt  = (idx_r == '0) ? acc0_r : mem_word;
          out_index_nxt = PHSH_IDX_OUT_W'(idx_r);
          out_last_nxt  = (idx_r == w_last);
        end
      end
      OP_EINC: begin
        idx_nxt = idx_r + idx_t'(1);
      end
      OP_CLEAR: begin
        acc0_nxt  = '0;
        prev_nxt  = '0;
        pos_nxt   = '0;
        start_nxt = 1'b1;
        pad_nxt   = 1'b0;
        valid_nxt = '0;
      end
      default: begin
      end
    endcase
  end

  // valid bit of the entry being read travels with the read data
  always_comb begin
    rd_valid_nxt = rd_valid_r;
    if (ram_re) begin
      rd_valid_nxt = (32'(ram_raddr) < 32'(MAX_WORDS)) ? valid_r[ram_raddr] : 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      words_cfg_r <= PHSH_CFG_RESET;
      acc0_r      <= '0;
      prev_r      <= '0;
      pos_r       <= '0;
      start_r     <= 1'b1;
      pad_r       <= 1'b0;
      idx_r       <= '0;
      valid_r     <= '0;
      rd_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        words_cfg_r <= cfg_data;
      end
      acc0_r      <= acc0_nxt;
      prev_r      <= prev_nxt;
      pos_r       <= pos_nxt;
      start_r     <= start_nxt;
      pad_r       <= pad_nxt;
      idx_r       <= idx_nxt;
      valid_r     <= valid_nxt;
      rd_valid_r  <= rd_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers: hold the byte of the last transfer and the output word
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      byte_r <= in_tdata;
      last_r <= in_tlast;
    end
    src_r       <= src_nxt;
    out_word_r  <= out_word_nxt;
    out_index_r <= out_index_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, out_index_r, out_word_r};
  assign out_tlast  = out_last_r;

endmodule

// File: bench/tb.sv
`timescale 1ns / 1ps
// Self-checking bench for popcount_shift_byte_hash_top: byte messages in, hash words out.
// Holds its own model of the hash in a scoreboard class. Depends on phsh_pkg and the RTL.

typedef struct packed {
  logic [31:0] hash;
  logic [4:0]  index;
  logic        last;
} hash_word_t;

class hash_scoreboard;
  logic [31:0] store [32];
  logic [7:0]  prev_byte;
  int unsigned chunk_pos;
  bit          msg_start;
  logic [phsh_pkg::PHSH_CFG_W-1:0] word_count;
  hash_word_t  expected_words [$];
  int unsigned errors;
  int unsigned words_checked;
  int unsigned messages;

  function new();
    foreach (store[i]) store[i] = '0;
    prev_byte     = '0;
    chunk_pos     = 0;
    msg_start     = 1'b1;
    word_count    = phsh_pkg::PHSH_CFG_RESET;
    errors        = 0;
    words_checked = 0;
    messages      = 0;
  endfunction

  // Zero counts as one word, anything past the store depth as the full store
  function int unsigned active_words();
    if (word_count == 0) return 1;
    if (word_count > 32) return 32;
    return word_count;
  endfunction

  function int unsigned bit_count(logic [7:0] v);
    int unsigned n;
    n = 0;
    for (int b = 0; b < 8; b++) n += v[b];
    return n;
  endfunction

  // Each word feeds its top nibble and bits 23:16 into the next, already-updated words first
  function void walk_carries(int unsigned w);
    logic [31:0] v;
    for (int unsigned n = 0; n + 1 < w; n++) begin
      v = store[n];
      store[n+1] += {4'h0, v[31:28], 24'h0};
      store[n+1] += {24'h0, v[23:16]};
    end
  endfunction

  function void fold_byte(logic [7:0] c, int unsigned w);
    int unsigned shift;
    if (msg_start) begin
      prev_byte = c;
      msg_start = 1'b0;
    end
    shift = bit_count(c ^ prev_byte);
    store[0] += 32'(bit_count(c)) << 24;
    store[0] += 32'(c) << shift;
    prev_byte = c;
    chunk_pos++;
    if ((chunk_pos % 16) == 0 || chunk_pos >= 4 * w) begin
      walk_carries(w);
      if (chunk_pos >= 4 * w) chunk_pos = 0;
    end
  endfunction

  function void note_byte(logic [7:0] d, logic last);
    int unsigned w;
    hash_word_t  e;
    w = active_words();
    fold_byte(d, w);
    if (!last) return;
    // pad the open chunk with position bytes; a full chunk when it closed exactly
    do fold_byte(8'(chunk_pos), w); while (chunk_pos != 0);
    for (int unsigned n = 0; n < w; n++) begin
      e.hash  = store[n];
      e.index = 5'(n);
      e.last  = (n + 1 == w);
      expected_words.push_back(e);
    end
    foreach (store[i]) store[i] = '0;
    prev_byte = '0;
    chunk_pos = 0;
    msg_start = 1'b1;
    messages++;
  endfunction

  function void note_config(logic [phsh_pkg::PHSH_CFG_W-1:0] v);
    word_count = v;
  endfunction

  function int unsigned pending();
    return expected_words.size();
  endfunction

  function void check_word(logic [31:0] h, logic [4:0] idx, logic last);
    hash_word_t e;
    if (expected_words.size() == 0) begin
      $error("hash word %h (index %0d) arrived with nothing expected", h, idx);
      errors++;
      return;
    end
    e = expected_words.pop_front();
    words_checked++;
    if (h !== e.hash) begin
      $error("hash_word: expected %h, actual %h", e.hash, h);
      errors++;
    end
    if (idx !== e.index) begin
      $error("word_index: expected %0d, actual %0d", e.index, idx);
      errors++;
    end
    if (last !== e.last) begin
      $error("last_word: expected %0b, actual %0b", e.last, last);
      errors++;
    end
  endfunction
endclass

module tb;
  localparam int unsigned LIMIT        = 1000000;  // cycles before the run is abandoned
  localparam int unsigned SETTLE       = 64;       // covers a byte plus a full carry walk
  localparam int unsigned HOLD_CYCLES  = 2000;     // long receiver hold-off
  localparam int unsigned TARGET_BYTES = 460;
  localparam int unsigned QUIET_FROM   = 400;      // no idling from here on

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic [7:0]  in_tdata = '0;      // [7:0] data_byte
  logic        in_tlast = 1'b0;    // last_byte
  logic        in_tready;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;          // [31:0] hash_word, [36:32] word_index
  logic        out_tlast;          // last_word
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [phsh_pkg::PHSH_CFG_W-1:0] cfg_data = '0;  // hash_words

  hash_scoreboard sb = new();

  int unsigned bytes_sent    = 0;
  int unsigned cfg_writes    = 0;
  int unsigned in_idle_pct   = 0;
  int unsigned out_stall_pct = 0;
  int unsigned hold_requests = 0;
  int unsigned cycle_count   = 0;
  bit          quiet         = 1'b0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  popcount_shift_byte_hash_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  // Check every result transfer against the oldest expected word
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      sb.check_word(out_tdata[31:0], out_tdata[36:32], out_tlast);
  end

  // Abandon a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT) begin
      $error("run stopped after %0d cycles, %0d words still expected", LIMIT, sb.pending());
      $display("FAILED: results differ");
      $finish;
    end
  end

  // Receiver: random stall bursts, a long hold-off on request, always ready when quiet
  initial begin
    int unsigned served;
    int unsigned n;
    served = 0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (served != hold_requests) begin
        served = hold_requests;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
      end else if (!quiet && $urandom_range(0, 99) < out_stall_pct) begin
        n = $urandom_range(1, 18);
        out_tready <= 1'b0;
        repeat (n - 1) @(negedge clk);
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Offer one byte, optionally after an idle burst, and hold it until the transfer
  task automatic send_byte(input logic [7:0] d, input logic last);
    int unsigned gap;
    if (bytes_sent >= QUIET_FROM) quiet = 1'b1;
    if (!quiet && $urandom_range(0, 99) < in_idle_pct) begin
      gap = $urandom_range(1, 18);
      @(negedge clk);
      in_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= d;
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
    sb.note_byte(d, last);
    bytes_sent++;
  endtask

  // Drop valid so the byte just transferred is not taken twice
  task automatic pause_input();
    @(negedge clk);
    in_tvalid <= 1'b0;
  endtask

  task automatic wait_drain();
    pause_input();
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // Only called with no result outstanding; let the block finish its walk or clear first
  task automatic write_word_count(input logic [phsh_pkg::PHSH_CFG_W-1:0] v);
    pause_input();
    repeat (SETTLE) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    sb.note_config(v);
    cfg_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Byte content styles: random, a constant fill, a byte and its complement, 00/FF only
  task automatic send_message(input int unsigned len, input int unsigned style);
    logic [7:0] base;
    logic [7:0] b;
    base = 8'($urandom);
    for (int unsigned i = 0; i < len; i++) begin
      case (style)
        0:       b = 8'($urandom);
        1:       b = base;
        2:       b = i[0] ? ~base : base;
        default: b = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      endcase
      send_byte(b, i + 1 == len);
    end
  endtask

  // Small word counts dominate; the extremes and out-of-range values still appear
  function automatic logic [phsh_pkg::PHSH_CFG_W-1:0] pick_word_count();
    case ($urandom_range(0, 15))
      0:       return 6'd0;
      1:       return 6'd1;
      2:       return 6'd32;
      3:       return 6'd33;
      4:       return 6'd63;
      5:       return 6'($urandom_range(0, 63));
      default: return 6'($urandom_range(2, 10));
    endcase
  endfunction

  // Favour lengths that land on chunk ends and on the sixteen-byte walk point
  function automatic int unsigned pick_length(input int unsigned chunk);
    case ($urandom_range(0, 9))
      0:       return 1;
      1, 2: begin
        if (chunk <= 24) return chunk * $urandom_range(1, 2);
        if (chunk <= 48) return chunk;
        return $urandom_range(1, 24);
      end
      3:       return $urandom_range(15, 17);
      default: return $urandom_range(2, 24);
    endcase
  endfunction

  function automatic int unsigned pick_pct();
    case ($urandom_range(0, 2))
      0:       return 0;
      1:       return 8;
      default: return 25;
    endcase
  endfunction

  initial begin
    logic [7:0] mixed [6];
    int unsigned phase;
    int unsigned n_msgs;
    mixed = '{8'h55, 8'hAA, 8'h0F, 8'hF0, 8'h80, 8'h01};
    phase = 0;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: two lone-byte messages and a six-byte message at the reset word count, each padded to a chunk
    send_byte(8'hFF, 1'b1);
    send_byte(8'h00, 1'b1);
    for (int i = 0; i < 6; i++) send_byte(mixed[i], i == 5);
    wait_drain();

    // Zero words counts as one; four bytes fill the chunk exactly, so a full pad follows
    write_word_count(6'd0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b1);
    wait_drain();

    // All-ones count clamps to the full store; shrink it mid-message past the chunk end
    write_word_count(6'd63);
    for (int i = 0; i < 10; i++) send_byte(8'(i * 37 + 3), 1'b0);
    write_word_count(6'd2);
    send_byte(8'hC3, 1'b0);
    send_byte(8'h7E, 1'b0);
    send_byte(8'h18, 1'b1);
    wait_drain();

    // Random phases: new word count, new idling mix, a few messages, then drain
    while (bytes_sent < TARGET_BYTES) begin
      if (bytes_sent >= QUIET_FROM) quiet = 1'b1;
      write_word_count(pick_word_count());
      in_idle_pct   = pick_pct();
      out_stall_pct = pick_pct();
      if (phase == 1) hold_requests++;
      n_msgs = $urandom_range(2, 5);
      repeat (n_msgs) send_message(pick_length(4 * sb.active_words()), $urandom_range(0, 3));
      wait_drain();
      phase++;
    end

    repeat (40) @(posedge clk);
    $display("Run covered %0d bytes in %0d messages across %0d word-count writes.",
             bytes_sent, sb.messages, cfg_writes);
    $display("%0d hash words compared, %0d field mismatches.", sb.words_checked, sb.errors);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end
endmodule

// File: files.f
rtl/core/phsh_pkg.sv
rtl/core/phsh_ram.sv
rtl/core/phsh_seq.sv
rtl/core/popcount_shift_byte_hash_top.sv
bench/tb.sv
